>>> hw/rtl/q_learning_action_update_assert.svh
// Assertion macros for the Q-learning action table.
// Included by q_learning_action_update.sv; expects aclk and aresetn in scope.
`ifndef Q_LEARNING_ACTION_UPDATE_ASSERT_SVH
`define Q_LEARNING_ACTION_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define QLAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QLAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/qlau_pkg.sv
// Package for the Q-learning action table: control word types, step numbers,
// register indexes and the microcode program. No dependencies.
`timescale 1ns / 1ps

package qlau_pkg;

    // Step counter width and step numbers of the program.
    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] STEP_FETCH  = 4'd1;
    localparam logic [PC_W-1:0] STEP_QLOAD  = 4'd2;
    localparam logic [PC_W-1:0] STEP_REWARD = 4'd3;
    localparam logic [PC_W-1:0] STEP_TARGET = 4'd4;
    localparam logic [PC_W-1:0] STEP_MIXQ   = 4'd5;
    localparam logic [PC_W-1:0] STEP_SUM    = 4'd6;
    localparam logic [PC_W-1:0] STEP_WRITE  = 4'd7;
    localparam logic [PC_W-1:0] STEP_LOAD   = 4'd8;
    localparam logic [PC_W-1:0] STEP_SCAN0  = 4'd9;
    localparam logic [PC_W-1:0] STEP_SCAN   = 4'd10;
    localparam logic [PC_W-1:0] STEP_DONE   = 4'd11;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TX_RX_WEIGHT = 2'd0;
    localparam logic [1:0] REG_QUEUE_WEIGHT = 2'd1;
    localparam logic [1:0] REG_LEARN_RATE   = 2'd2;
    localparam logic [1:0] REG_DISCOUNT     = 2'd3;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_TX = 3'd0,  // tx_rx_weight * (sent + received)
        MUL_QW = 3'd1,  // queue_weight * (before - after)
        MUL_GQ = 3'd2,  // discount * Q
        MUL_OQ = 3'd3,  // (1 - learn_rate) * Q
        MUL_LT = 3'd4   // learn_rate * target
    } mul_sel_t;

    // Accumulator operation on the registered product.
    typedef enum logic [2:0] {
        ACC_HOLD    = 3'd0,
        ACC_LOAD    = 3'd1,
        ACC_SUB     = 3'd2,
        ACC_ADD     = 3'd3,
        ACC_ADD_SHR = 3'd4
    } acc_op_t;

    // Table read address source.
    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_IDX  = 2'd1,
        RD_ZERO = 2'd2,
        RD_NEXT = 2'd3
    } rd_sel_t;

    // Table write source.
    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_UPDATE = 2'd1,
        WR_LOAD   = 2'd2
    } wr_sel_t;

    // Handshake that holds the step counter.
    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_IN   = 2'd1,
        WAIT_OUT  = 2'd2
    } wait_t;

    // Jump condition.
    typedef enum logic [1:0] {
        JC_NEVER     = 2'd0,
        JC_ALWAYS    = 2'd1,
        JC_LOAD      = 2'd2,
        JC_SCAN_MORE = 2'd3
    } jmp_t;

    typedef struct packed {
        mul_sel_t        mul;
        acc_op_t         acc;
        rd_sel_t         rd;
        logic            q_load;
        logic            reward_load;
        wr_sel_t         wr;
        logic            scan;
        logic            out_load;
        wait_t           wt;
        jmp_t            jc;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Microcode program: one control word per step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '0;
        unique case (pc)
            STEP_IDLE: begin
                cw.wt = WAIT_IN;
            end
            STEP_FETCH: begin
                cw.rd     = RD_IDX;
                cw.mul    = MUL_TX;
                cw.jc     = JC_LOAD;
                cw.target = STEP_LOAD;
            end
            STEP_QLOAD: begin
                cw.q_load = 1'b1;
                cw.mul    = MUL_QW;
                cw.acc    = ACC_LOAD;
            end
            STEP_REWARD: begin
                cw.mul = MUL_GQ;
                cw.acc = ACC_SUB;
            end
            STEP_TARGET: begin
                cw.mul         = MUL_OQ;
                cw.acc         = ACC_ADD_SHR;
                cw.reward_load = 1'b1;
            end
            STEP_MIXQ: begin
                cw.mul = MUL_LT;
                cw.acc = ACC_LOAD;
            end
            STEP_SUM: begin
                cw.acc = ACC_ADD;
            end
            STEP_WRITE: begin
                cw.wr     = WR_UPDATE;
                cw.jc     = JC_ALWAYS;
                cw.target = STEP_SCAN0;
            end
            STEP_LOAD: begin
                cw.wr = WR_LOAD;
            end
            STEP_SCAN0: begin
                cw.rd = RD_ZERO;
            end
            STEP_SCAN: begin
                cw.rd     = RD_NEXT;
                cw.scan   = 1'b1;
                cw.jc     = JC_SCAN_MORE;
                cw.target = STEP_SCAN;
            end
            STEP_DONE: begin
                cw.wt       = WAIT_OUT;
                cw.out_load = 1'b1;
                cw.jc       = JC_ALWAYS;
                cw.target   = STEP_IDLE;
            end
            default: begin
                cw.jc     = JC_ALWAYS;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> hw/rtl/q_learning_action_update.sv
// Q-learning action table with a microcoded update datapath.
// Depends on qlau_pkg and q_learning_action_update_assert.svh.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one item per word: tuser is the mode (update or
// load), tdata the action index, the four counts and the load value. Every
// item returns one master stream word with the best action, the new entry
// value, the reward and the saturation flag.
// The user must write configuration over the APB port only while the block is
// idle; the block does not enforce this. The step program drives one shared
// multiplier through five products in sequence for an update, then the
// best-action scan reads the table's read port once per entry; a load writes
// its value to the table before the scan. A new item is accepted only in the
// idle step, after the last one has entered the output register.
// The result sits in an output register, so the block finishes its next item
// while a result waits; it stalls only in its last step when the output is
// still full. Reset clears the table to zero through per-entry valid bits,
// restores the register defaults and empties the output; no clearing pass.
module q_learning_action_update
    import qlau_pkg::*;
#(
    parameter int NUM_ACTIONS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: action_index[1:0], sent_count[9:2], received_count[17:10],
    // queue_before[25:18], queue_after[33:26], load_value[65:34], zero pad.
    input  logic [71:0] s_tdata,
    // tuser from bit 0: mode.
    input  logic [0:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: best_action[1:0], new_q_value[33:2],
    // reward_value[56:34], saturated[57], zero pad.
    output logic [63:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(NUM_ACTIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACTIONS - 1);
    localparam int ACC_W = 52;

    // Configuration registers.
    logic [11:0] tx_rx_weight_reg;
    logic [11:0] queue_weight_reg;
    logic [15:0] learn_rate_reg;
    logic [15:0] discount_reg;

    // Sequencer.
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      cw;
    logic            s_accept;
    logic            out_free;
    logic            wait_hold;
    logic            jump_taken;

    // Latched input item.
    logic             mode_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       sent_reg, recv_reg, qb_reg, qa_reg;
    logic [31:0]      load_reg;

    // Datapath.
    logic signed [17:0]      mul_a;
    logic signed [33:0]      mul_b;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]      q_reg;
    logic [22:0]             reward_reg;
    logic signed [31:0]      result_reg;
    logic                    sat_reg;
    logic [8:0]              count_sum;
    logic signed [9:0]       queue_diff;
    logic signed [35:0]      nq;
    logic                    nq_ovf;
    logic signed [31:0]      upd_val;

    // Table and scan.
    logic [31:0]          q_mem [NUM_ACTIONS];
    logic [NUM_ACTIONS-1:0] q_valid_reg;
    logic [31:0]          rd_data_reg;
    logic                 rd_valid_reg;
    logic signed [31:0]   rd_q;
    logic [IDX_W-1:0]     raddr;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     scan_next;
    logic signed [31:0]   best_val_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 wr_en;
    logic [31:0]          wr_data;

    // Output register.
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    // APB access: always ready, reads return the register values.
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_TX_RX_WEIGHT: prdata = 32'(tx_rx_weight_reg);
            REG_QUEUE_WEIGHT: prdata = 32'(queue_weight_reg);
            REG_LEARN_RATE:   prdata = 32'(learn_rate_reg);
            REG_DISCOUNT:     prdata = 32'(discount_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_rx_weight_reg <= 12'd768;
            queue_weight_reg <= 12'd384;
            learn_rate_reg   <= 16'd6554;
            discount_reg     <= 16'd58982;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_TX_RX_WEIGHT: tx_rx_weight_reg <= pwdata[11:0];
                REG_QUEUE_WEIGHT: queue_weight_reg <= pwdata[11:0];
                REG_LEARN_RATE:   learn_rate_reg   <= pwdata[15:0];
                REG_DISCOUNT:     discount_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Step counter: hold on an unmet handshake, else jump or advance.
    assign cw        = ucode(pc_reg);
    assign s_tready  = (pc_reg == STEP_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign scan_next = (cmp_idx_reg == LAST_IDX) ? '0 : cmp_idx_reg + 1'b1;

    always_comb begin
        case (cw.wt)
            WAIT_IN:  wait_hold = !s_tvalid;
            WAIT_OUT: wait_hold = !out_free;
            default:  wait_hold = 1'b0;
        endcase
        case (cw.jc)
            JC_ALWAYS:    jump_taken = 1'b1;
            JC_LOAD:      jump_taken = mode_reg;
            JC_SCAN_MORE: jump_taken = (cmp_idx_reg != LAST_IDX);
            default:      jump_taken = 1'b0;
        endcase
        if (wait_hold) begin
            pc_next = pc_reg;
        end else if (jump_taken) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Capture the input word; an index past the table folds back onto it.
    // The index field is two bits and the table holds at least two entries,
    // so one subtraction covers every case.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser[0];
            if (32'(s_tdata[1:0]) >= NUM_ACTIONS) begin
                idx_reg <= IDX_W'(32'(s_tdata[1:0]) - NUM_ACTIONS);
            end else begin
                idx_reg <= IDX_W'(s_tdata[1:0]);
            end
            sent_reg <= s_tdata[9:2];
            recv_reg <= s_tdata[17:10];
            qb_reg   <= s_tdata[25:18];
            qa_reg   <= s_tdata[33:26];
            load_reg <= s_tdata[65:34];
        end
    end

    // Operand selection for the shared multiplier.
    assign count_sum  = {1'b0, sent_reg} + {1'b0, recv_reg};
    assign queue_diff = signed'({2'b00, qb_reg}) - signed'({2'b00, qa_reg});

    always_comb begin
        case (cw.mul)
            MUL_TX: begin
                mul_a = signed'({6'd0, tx_rx_weight_reg});
                mul_b = signed'({25'd0, count_sum});
            end
            MUL_QW: begin
                mul_a = signed'({6'd0, queue_weight_reg});
                mul_b = {{24{queue_diff[9]}}, queue_diff};
            end
            MUL_GQ: begin
                mul_a = signed'({2'd0, discount_reg});
                mul_b = {{2{q_reg[31]}}, q_reg};
            end
            MUL_OQ: begin
                mul_a = signed'({1'b0, 17'h10000 - {1'b0, learn_rate_reg}});
                mul_b = {{2{q_reg[31]}}, q_reg};
            end
            MUL_LT: begin
                mul_a = signed'({2'd0, learn_rate_reg});
                mul_b = acc_reg[33:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Accumulator on the registered product.
    always_comb begin
        case (cw.acc)
            ACC_LOAD:    acc_next = prod_reg;
            ACC_SUB:     acc_next = acc_reg - prod_reg;
            ACC_ADD:     acc_next = acc_reg + prod_reg;
            ACC_ADD_SHR: acc_next = acc_reg + (prod_reg >>> 16);
            default:     acc_next = acc_reg;
        endcase
    end

    // Final shift and saturation to the 32-bit range.
    assign nq      = acc_reg[ACC_W-1:16];
    assign nq_ovf  = !((&nq[35:31]) || !(|nq[35:31]));
    assign upd_val = nq_ovf ? (nq[35] ? 32'sh80000000 : 32'sh7FFFFFFF) : nq[31:0];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cw.q_load) begin
            q_reg <= rd_q;
        end
        if (cw.reward_load) begin
            reward_reg <= acc_reg[22:0];
        end
        if (cw.wr == WR_UPDATE) begin
            result_reg <= upd_val;
            sat_reg    <= nq_ovf;
        end else if (cw.wr == WR_LOAD) begin
            result_reg <= signed'(load_reg);
            sat_reg    <= 1'b0;
            reward_reg <= '0;
        end
    end

    // Table port: one write and one registered read per cycle.
    assign wr_en   = (cw.wr != WR_NONE);
    assign wr_data = (cw.wr == WR_LOAD) ? load_reg : upd_val;
    assign rd_q    = rd_valid_reg ? signed'(rd_data_reg) : '0;

    always_comb begin
        case (cw.rd)
            RD_IDX:  raddr = idx_reg;
            RD_NEXT: raddr = scan_next;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= q_mem[raddr];
    end

    // Entries that were never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                q_valid_reg[idx_reg] <= 1'b1;
            end
            rd_valid_reg <= q_valid_reg[raddr];
        end
    end

    // Best-action scan: the first strictly larger value wins, so ties keep
    // the lowest index.
    always_ff @(posedge aclk) begin
        if (cw.rd == RD_ZERO) begin
            cmp_idx_reg <= '0;
        end else if (cw.rd == RD_NEXT) begin
            cmp_idx_reg <= scan_next;
        end
        if (cw.scan && ((cmp_idx_reg == '0) || (rd_q > best_val_reg))) begin
            best_val_reg <= rd_q;
            best_idx_reg <= cmp_idx_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cw.out_load && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.out_load && out_free) begin
            out_data_reg <= {6'd0, sat_reg, reward_reg, result_reg, 2'(best_idx_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks on the sequencer and datapath.
`include "q_learning_action_update_assert.svh"

    `QLAU_ASSERT_NEXT(a_accept_fetch, s_accept, pc_reg == STEP_FETCH,
        "accepted word did not start the fetch step")
    `QLAU_ASSERT_NEXT(a_done_holds, (pc_reg == STEP_DONE) && !out_free,
        pc_reg == STEP_DONE, "result step left while the output was full")
    `QLAU_ASSERT_NOW(a_sat_clipped, sat_reg,
        (result_reg == 32'sh7FFFFFFF) || (result_reg == 32'sh80000000),
        "saturation flag set on an unclipped value")
    `QLAU_ASSERT_NOW(a_scan_bound, pc_reg == STEP_SCAN, cmp_idx_reg <= LAST_IDX,
        "scan index ran past the table")

endmodule
